// ===== sv/hbd_pkg.sv =====
package hbd_pkg;

   // field and state widths
   localparam int SAMPLE_BITS   = 10;
   localparam int HISTORY_DEPTH = 10;
   localparam int INTERVAL_BITS = 12;
   localparam int ELAPSED_BITS  = 8;
   localparam int TIME_BITS     = 32;
   localparam int BPM_BITS      = 8;
   localparam int REFRACT_BITS  = 12;
   localparam int LOST_BITS     = 16;

   // register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   // history sum and shared divider
   localparam int SUM_BITS      = INTERVAL_BITS + $clog2(HISTORY_DEPTH);
   localparam int DIV_BITS      = (SUM_BITS > 16) ? SUM_BITS : 16;
   localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);
   localparam int HIST_CNT_BITS = $clog2(HISTORY_DEPTH + 1);

   localparam logic [INTERVAL_BITS-1:0] INTERVAL_MAX  = '1;
   localparam logic [DIV_BITS-1:0]      MS_PER_MINUTE = DIV_BITS'(60000);
   localparam logic [BPM_BITS-1:0]      BPM_MAX       = '1;

   // reset values
   localparam logic [SAMPLE_BITS-1:0]   LED_LEVEL_RST     = SAMPLE_BITS'(600);
   localparam logic [REFRACT_BITS-1:0]  REFRACT_RST       = REFRACT_BITS'(250);
   localparam logic [LOST_BITS-1:0]     LOST_RST          = LOST_BITS'(2500);
   localparam logic [SAMPLE_BITS-1:0]   START_THR_RST     = SAMPLE_BITS'(525);
   localparam logic [SAMPLE_BITS-1:0]   REST_LEVEL_RST    = SAMPLE_BITS'(512);
   localparam logic [SAMPLE_BITS-1:0]   PEAK_RST          = SAMPLE_BITS'(512);
   localparam logic [INTERVAL_BITS-1:0] LAST_INTERVAL_RST = INTERVAL_BITS'(600);

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LED_LEVEL       = CSR_ADDR_BITS'(0);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_REFRACTORY_MS   = CSR_ADDR_BITS'(1);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LOST_SIGNAL_MS  = CSR_ADDR_BITS'(2);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_START_THRESHOLD = CSR_ADDR_BITS'(3);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_REST_LEVEL      = CSR_ADDR_BITS'(4);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0]  sample;
      logic [ELAPSED_BITS-1:0] elapsed_ms;
   } hbd_req_type;

   typedef struct packed {
      logic [BPM_BITS-1:0]    bpm;
      logic                   beat_start;
      logic                   beat_active;
      logic [SAMPLE_BITS-1:0] level;
      logic                   led_on;
   } hbd_rsp_type;

   // history commands: load pushes (or fills), sum then walks the entries
   typedef struct packed {
      logic                     load;
      logic                     fill;
      logic                     sum;
      logic [INTERVAL_BITS-1:0] interval;
   } hbd_hist_ctl_type;

   typedef struct packed {
      logic                done;
      logic [SUM_BITS-1:0] sum;
   } hbd_hist_sts_type;

endpackage

// ===== sv/hbd_divider.sv =====
module hbd_divider
   import hbd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] num,
   input  logic [DIV_BITS-1:0] den,
   output logic                done,
   output logic [DIV_BITS-1:0] quo
);

   logic [DIV_BITS-1:0]     rem_ff, rem_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [DIV_BITS-1:0]     den_ff, den_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_BITS:0]       shifted;
   logic [DIV_BITS:0]       trial;

   // restoring division, one quotient bit a cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_BITS-1]};
      trial   = shifted - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = DIV_CNT_BITS'(DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = trial[DIV_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== sv/hbd_history.sv =====
module hbd_history
   import hbd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  hbd_hist_ctl_type ctl,
   output hbd_hist_sts_type sts
);

   logic [INTERVAL_BITS-1:0] hist_ff [HISTORY_DEPTH];
   logic [INTERVAL_BITS-1:0] hist_in [HISTORY_DEPTH];
   logic [SUM_BITS-1:0]      acc_ff, acc_in;
   logic [HIST_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   // sum walks the line by rotating it once through the adder
   always_comb begin
      hist_in = hist_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.load) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (ctl.fill || i == HISTORY_DEPTH - 1) begin
               hist_in[i] = ctl.interval;
            end else begin
               hist_in[i] = hist_ff[i+1];
            end
         end
         acc_in  = '0;
         cnt_in  = HIST_CNT_BITS'(HISTORY_DEPTH);
         busy_in = ctl.sum;
      end else if (busy_ff) begin
         for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            hist_in[i] = hist_ff[i+1];
         end
         hist_in[HISTORY_DEPTH-1] = hist_ff[0];
         acc_in = acc_ff + SUM_BITS'(hist_ff[0]);
         cnt_in = cnt_ff - HIST_CNT_BITS'(1);
         if (cnt_ff == HIST_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (reset) begin
         hist_ff <= '{default: '0};
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         hist_ff <= hist_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done = done_ff;
   assign sts.sum  = acc_ff;

endmodule

// ===== sv/heartbeat_bpm_detector.sv =====
// heartbeat detector with adaptive threshold and bpm estimate
// req channel: one item is a pulse sample plus the ms elapsed since the previous
// sample; rsp channel: one item per request with bpm, beat flags, the current
// threshold and the led indicator. csr port: plain write, index selects the
// register (led level, refractory ms, lost-signal ms, start threshold, rest level)
// sequence: an item with no new beat passes through DIFF, TEST, APPLY, FINISH
// and OUT; the first beat after reset or signal loss goes from APPLY straight
// to OUT; an item that records any later beat also passes SUM, MEAN and RATE,
// where the history adder walks all entries and two passes of the
// one-bit-a-cycle divider compute the mean interval, then 60000 / mean; a zero
// mean skips the second pass
// throughput: one item at a time; req_ready is high only while the sequencer
// waits for an item, so the next item is taken only after the previous result
// stall: the result sits in an output register; a new item is accepted while it
// waits, and that item's result is held back until the register is taken
// reset: registers return to defaults, threshold to the start level, history
// to zero, bpm to 0; no clearing pass, req_ready rises once reset drops
module heartbeat_bpm_detector
   import hbd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  hbd_req_type              req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hbd_rsp_type              rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,    // wait for an item
      ST_DIFF,    // time since last beat
      ST_TEST,    // all compares against old state
      ST_APPLY,   // peak, trough, beat start, history update
      ST_SUM,     // history adder walks the entries
      ST_MEAN,    // divider: sum / depth
      ST_RATE,    // divider: 60000 / mean
      ST_FINISH,  // end of beat and lost signal
      ST_OUT      // hand the item to the output register
   } state_type;

   typedef struct packed {
      logic past_frac;
      logic gt_thr;
      logic lt_thr;
      logic lt_trough;
      logic gt_peak;
      logic gt_refract;
      logic gt_lost;
   } test_flags_type;

   state_type                state_ff, state_in;

   // configuration
   logic [SAMPLE_BITS-1:0]   led_level_ff, led_level_in;
   logic [REFRACT_BITS-1:0]  refract_ff, refract_in;
   logic [LOST_BITS-1:0]     lost_ff, lost_in;
   logic [SAMPLE_BITS-1:0]   rest_level_ff, rest_level_in;

   // detector state
   logic [SAMPLE_BITS-1:0]   thr_ff, thr_in;
   logic [SAMPLE_BITS-1:0]   peak_ff, peak_in;
   logic [SAMPLE_BITS-1:0]   trough_ff, trough_in;
   logic [INTERVAL_BITS-1:0] last_int_ff, last_int_in;
   logic [TIME_BITS-1:0]     ms_ff, ms_in;
   logic [TIME_BITS-1:0]     last_beat_ff, last_beat_in;
   logic                     in_beat_ff, in_beat_in;
   logic                     first_ff, first_in;
   logic                     second_ff, second_in;
   logic [BPM_BITS-1:0]      bpm_ff, bpm_in;
   logic                     led_ff, led_in;

   // per-item working registers
   logic [SAMPLE_BITS-1:0]   sample_ff, sample_in;
   logic [TIME_BITS-1:0]     n_ff, n_in;
   test_flags_type           flags_ff, flags_in;
   logic                     started_ff, started_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   hbd_rsp_type              rsp_data_ff, rsp_data_in;

   // shared units
   hbd_hist_ctl_type         hist_ctl;
   hbd_hist_sts_type         hist_sts;
   logic                     div_start;
   logic [DIV_BITS-1:0]      div_num;
   logic [DIV_BITS-1:0]      div_den;
   logic                     div_done;
   logic [DIV_BITS-1:0]      div_quo;

   // combinational helpers
   logic [TIME_BITS+2:0]     n_x5;
   logic [INTERVAL_BITS+1:0] li_x3;
   logic [INTERVAL_BITS-1:0] interval_sat;
   logic                     beat;
   logic signed [SAMPLE_BITS:0] mid_diff;
   logic signed [SAMPLE_BITS:0] mid_round;
   logic signed [SAMPLE_BITS:0] mid_half;
   logic [SAMPLE_BITS-1:0]   mid;

   hbd_history u_history (
      .clock (clock),
      .reset (reset),
      .ctl   (hist_ctl),
      .sts   (hist_sts)
   );

   hbd_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      // 5*n against 3*last interval, exact
      n_x5  = {3'b000, n_ff} + {1'b0, n_ff, 2'b00};
      li_x3 = {2'b00, last_int_ff} + {1'b0, last_int_ff, 1'b0};

      interval_sat = (n_ff > TIME_BITS'(INTERVAL_MAX)) ? INTERVAL_MAX
                                                       : n_ff[INTERVAL_BITS-1:0];
      beat = flags_ff.gt_refract && flags_ff.gt_thr && !in_beat_ff && flags_ff.past_frac;

      // midpoint trough + (peak - trough) / 2, halving toward zero
      mid_diff  = $signed({1'b0, peak_ff}) - $signed({1'b0, trough_ff});
      mid_round = mid_diff + $signed({{SAMPLE_BITS{1'b0}}, mid_diff[SAMPLE_BITS]});
      mid_half  = mid_round >>> 1;
      mid       = trough_ff + mid_half[SAMPLE_BITS-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      led_level_in  = led_level_ff;
      refract_in    = refract_ff;
      lost_in       = lost_ff;
      rest_level_in = rest_level_ff;
      thr_in        = thr_ff;
      peak_in       = peak_ff;
      trough_in     = trough_ff;
      last_int_in   = last_int_ff;
      ms_in         = ms_ff;
      last_beat_in  = last_beat_ff;
      in_beat_in    = in_beat_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      bpm_in        = bpm_ff;
      led_in        = led_ff;
      sample_in     = sample_ff;
      n_in          = n_ff;
      flags_in      = flags_ff;
      started_in    = started_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      hist_ctl          = '0;
      hist_ctl.interval = interval_sat;
      div_start         = 1'b0;
      div_num           = MS_PER_MINUTE;
      div_den           = div_quo;

      // register writes, taken only while idle by contract; the block does not enforce it
      if (csr_we) begin
         case (csr_addr)
            CSR_LED_LEVEL:       led_level_in  = csr_wdata[SAMPLE_BITS-1:0];
            CSR_REFRACTORY_MS:   refract_in    = csr_wdata[REFRACT_BITS-1:0];
            CSR_LOST_SIGNAL_MS:  lost_in       = csr_wdata[LOST_BITS-1:0];
            // start threshold only matters at reset, which restores its default
            CSR_START_THRESHOLD: ;
            CSR_REST_LEVEL:      rest_level_in = csr_wdata[SAMPLE_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in  = req_data.sample;
               ms_in      = ms_ff + TIME_BITS'(req_data.elapsed_ms);
               started_in = 1'b0;
               // led hysteresis: equal level holds
               if (req_data.sample > led_level_ff) begin
                  led_in = 1'b1;
               end else if (req_data.sample < led_level_ff) begin
                  led_in = 1'b0;
               end
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            n_in     = ms_ff - last_beat_ff;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            flags_in.past_frac  = n_x5 > (TIME_BITS+3)'(li_x3);
            flags_in.gt_thr     = sample_ff > thr_ff;
            flags_in.lt_thr     = sample_ff < thr_ff;
            flags_in.lt_trough  = sample_ff < trough_ff;
            flags_in.gt_peak    = sample_ff > peak_ff;
            flags_in.gt_refract = n_ff > TIME_BITS'(refract_ff);
            flags_in.gt_lost    = n_ff > TIME_BITS'(lost_ff);
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (flags_ff.lt_thr && flags_ff.past_frac && flags_ff.lt_trough) begin
               trough_in = sample_ff;
            end
            if (flags_ff.gt_thr && flags_ff.gt_peak) begin
               peak_in = sample_ff;
            end
            started_in = beat;
            if (beat) begin
               in_beat_in   = 1'b1;
               last_int_in  = interval_sat;
               last_beat_in = ms_ff;
               // second flag fills the whole history; a first beat skips the rest
               hist_ctl.load = second_ff || !first_ff;
               hist_ctl.fill = second_ff;
               hist_ctl.sum  = !first_ff;
               second_in     = first_ff;
               first_in      = 1'b0;
               state_in      = first_ff ? ST_OUT : ST_SUM;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SUM: begin
            if (hist_sts.done) begin
               div_start = 1'b1;
               div_num   = DIV_BITS'(hist_sts.sum);
               div_den   = DIV_BITS'(HISTORY_DEPTH);
               state_in  = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (div_done) begin
               if (div_quo == '0) begin
                  // zero mean interval saturates
                  bpm_in   = BPM_MAX;
                  state_in = ST_FINISH;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_RATE;
               end
            end
         end
         ST_RATE: begin
            if (div_done) begin
               bpm_in   = (div_quo > DIV_BITS'(BPM_MAX)) ? BPM_MAX
                                                         : div_quo[BPM_BITS-1:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // end of beat: threshold to the peak/trough midpoint
            if (flags_ff.lt_thr && in_beat_ff) begin
               in_beat_in = 1'b0;
               thr_in     = mid;
               peak_in    = mid;
               trough_in  = mid;
            end
            // lost signal overrides everything above
            if (flags_ff.gt_lost) begin
               thr_in       = rest_level_ff;
               peak_in      = rest_level_ff;
               trough_in    = rest_level_ff;
               last_beat_in = ms_ff;
               first_in     = 1'b1;
               second_in    = 1'b1;
               bpm_in       = '0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.bpm         = bpm_ff;
               rsp_data_in.beat_start  = started_ff;
               rsp_data_in.beat_active = in_beat_ff;
               rsp_data_in.level       = thr_ff;
               rsp_data_in.led_on      = led_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      n_ff        <= n_in;
      flags_ff    <= flags_in;
      started_ff  <= started_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         led_level_ff  <= LED_LEVEL_RST;
         refract_ff    <= REFRACT_RST;
         lost_ff       <= LOST_RST;
         rest_level_ff <= REST_LEVEL_RST;
         thr_ff        <= START_THR_RST;
         peak_ff       <= PEAK_RST;
         trough_ff     <= PEAK_RST;
         last_int_ff   <= LAST_INTERVAL_RST;
         ms_ff         <= '0;
         last_beat_ff  <= '0;
         in_beat_ff    <= 1'b0;
         first_ff      <= 1'b1;
         second_ff     <= 1'b0;
         bpm_ff        <= '0;
         led_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         led_level_ff  <= led_level_in;
         refract_ff    <= refract_in;
         lost_ff       <= lost_in;
         rest_level_ff <= rest_level_in;
         thr_ff        <= thr_in;
         peak_ff       <= peak_in;
         trough_ff     <= trough_in;
         last_int_ff   <= last_int_in;
         ms_ff         <= ms_in;
         last_beat_ff  <= last_beat_in;
         in_beat_ff    <= in_beat_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         bpm_ff        <= bpm_in;
         led_ff        <= led_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // divider results only arrive while the sequencer waits for them
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_MEAN || state_ff == ST_RATE))
      else $error("divider finished outside a divide step");

   // history sum only completes during the sum step
   a_hist_done_state: assert property (@(posedge clock) disable iff (reset)
      hist_sts.done |-> (state_ff == ST_SUM))
      else $error("history sum finished outside the sum step");

   // a beat that starts cannot end on the same item
   a_start_in_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.beat_start) |-> rsp_data_ff.beat_active)
      else $error("beat start reported without an active beat");
`endif

endmodule
